// ----- src/ising_spin_flip_update_top_assert.svh -----
// Assertion macros used by the spin-flip update controller.
`ifndef ISING_SPIN_FLIP_UPDATE_TOP_ASSERT_SVH
`define ISING_SPIN_FLIP_UPDATE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ISFU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ISFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ISFU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ISFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/isfu_pkg.sv -----
// Shared constants, codes and control types of the spin-flip update block.
package isfu_pkg;

	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 128;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);

	localparam int SIZE_W     = 8;   // rows_in_use / cols_in_use
	localparam int Q_W        = 16;  // Q8.8 config values
	localparam int THR_W      = 20;
	localparam int E_W        = 21;  // energy change, never overflows
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INERTIA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd4;

	// item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_FLIP  = 2'd2;

	// lattice read select
	localparam logic [2:0] NB_CTR = 3'd0;
	localparam logic [2:0] NB_UP  = 3'd1;
	localparam logic [2:0] NB_DN  = 3'd2;
	localparam logic [2:0] NB_LF  = 3'd3;
	localparam logic [2:0] NB_RT  = 3'd4;

	typedef struct packed {
		logic       load_item;
		logic       wr_spin;
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       calc_nbj;
		logic       calc_flip;
		logic       load_out;
	} isfu_cmd_t;

	typedef struct packed {
		logic       oob;
		logic [1:0] mode;
	} isfu_sts_t;

endpackage

// ----- src/isfu_in_if.sv -----
// Input word channel: site operation requests.
interface isfu_in_if import isfu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic [ROW_W-1:0]        row;
	logic [COL_W-1:0]        col;
	logic                    spin_value;
	logic signed [THR_W-1:0] threshold;

	modport source (output valid, mode, row, col, spin_value, threshold, input ready);
	modport sink   (input valid, mode, row, col, spin_value, threshold, output ready);
endinterface

// ----- src/isfu_out_if.sv -----
// Output word channel: per-item result.
interface isfu_out_if import isfu_pkg::*; ();
	logic valid;
	logic ready;
	logic spin;
	logic flipped;
	logic status;

	modport source (output valid, spin, flipped, status, input ready);
	modport sink   (input valid, spin, flipped, status, output ready);
endinterface

// ----- src/isfu_cfg_if.sv -----
// Configuration write channel.
interface isfu_cfg_if import isfu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/isfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module isfu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/isfu_datapath.sv -----
// Datapath: config registers, item registers, lattice RAM, energy evaluation.
module isfu_datapath import isfu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  isfu_cmd_t               cmd,
	output isfu_sts_t               sts,
	input  logic [1:0]              mode,
	input  logic [ROW_W-1:0]        row,
	input  logic [COL_W-1:0]        col,
	input  logic                    spin_value,
	input  logic signed [THR_W-1:0] threshold,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    res_spin,
	output logic                    res_flipped,
	output logic                    res_status
);

	function automatic logic [ADDR_W-1:0] site_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
	endfunction

	// config
	logic signed [Q_W-1:0] field_q, coupling_q, inertia_q;
	logic [SIZE_W-1:0]     rows_q, cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= '0;
			coupling_q <= Q_W'(256);
			inertia_q  <= '0;
			rows_q     <= SIZE_W'(MAX_ROWS);
			cols_q     <= SIZE_W'(MAX_COLS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIELD:    field_q    <= cfg_data[Q_W-1:0];
				CFG_COUPLING: coupling_q <= cfg_data[Q_W-1:0];
				CFG_INERTIA:  inertia_q  <= cfg_data[Q_W-1:0];
				CFG_ROWS:     rows_q     <= cfg_data[SIZE_W-1:0];
				CFG_COLS:     cols_q     <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// item
	logic [1:0]              mode_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic                    sv_q;
	logic signed [THR_W-1:0] thr_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= mode;
			row_q  <= row;
			col_q  <= col;
			sv_q   <= spin_value;
			thr_q  <= threshold;
		end
	end

	// geometry: clip sizes to storage, wrapped neighbor coordinates
	logic [SIZE_W-1:0] rows_eff, cols_eff;
	logic [ROW_W-1:0]  up_c, dn_c;
	logic [COL_W-1:0]  lf_c, rt_c;
	logic              oob_c;

	always_comb begin
		rows_eff = (rows_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_q;
		cols_eff = (cols_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_q;
		oob_c    = (SIZE_W'(row_q) >= rows_eff) || (SIZE_W'(col_q) >= cols_eff);
		up_c = (row_q == '0) ? ROW_W'(rows_eff - SIZE_W'(1)) : row_q - ROW_W'(1);
		dn_c = (SIZE_W'(row_q) + SIZE_W'(1) == rows_eff) ? '0 : row_q + ROW_W'(1);
		lf_c = (col_q == '0) ? COL_W'(cols_eff - SIZE_W'(1)) : col_q - COL_W'(1);
		rt_c = (SIZE_W'(col_q) + SIZE_W'(1) == cols_eff) ? '0 : col_q + COL_W'(1);
	end

	assign sts.oob  = oob_c;
	assign sts.mode = mode_q;

	// lattice read
	logic [ADDR_W-1:0] raddr;
	logic              rdata;

	always_comb begin
		case (cmd.rd_sel)
			NB_CTR:  raddr = site_addr(row_q, col_q);
			NB_UP:   raddr = site_addr(up_c, col_q);
			NB_DN:   raddr = site_addr(dn_c, col_q);
			NB_LF:   raddr = site_addr(row_q, lf_c);
			NB_RT:   raddr = site_addr(row_q, rt_c);
			default: raddr = site_addr(row_q, col_q);
		endcase
	end

	logic       rd_vld_s1;
	logic [2:0] rd_sel_s1;
	logic       ctr_q, up_q, dn_q, lf_q, rt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_sel_s1 <= cmd.rd_sel;
		if (rd_vld_s1) begin
			case (rd_sel_s1)
				NB_CTR:  ctr_q <= rdata;
				NB_UP:   up_q  <= rdata;
				NB_DN:   dn_q  <= rdata;
				NB_LF:   lf_q  <= rdata;
				NB_RT:   rt_q  <= rdata;
				default: ;
			endcase
		end
	end

	// energy: nb*J registered, then add, sign, penalty and compare
	logic [2:0]              ones_c;
	logic signed [4:0]       nb_c;
	logic signed [E_W-1:0]   nbj_q;
	logic                    allm_q;
	logic signed [E_W-1:0]   sum_c, e2_c, e_c, pen_c;
	logic                    flip_c, flip_q;

	always_comb begin
		ones_c = 3'(up_q) + 3'(dn_q) + 3'(lf_q) + 3'(rt_q);
		nb_c   = $signed({1'b0, ones_c, 1'b0}) - 5'sd4;
		sum_c  = E_W'(field_q) + nbj_q;
		e2_c   = sum_c <<< 1;
		pen_c  = allm_q ? E_W'(inertia_q) : '0;
		e_c    = ctr_q ? e2_c : (pen_c - e2_c);
		flip_c = e_c < E_W'(thr_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_nbj) begin
			nbj_q  <= E_W'(nb_c) * E_W'(coupling_q);
			allm_q <= (ones_c == '0);
		end
		if (cmd.calc_flip) begin
			flip_q <= flip_c;
		end
	end

	// lattice write: a write item, or a flip that is taken
	logic ram_we, ram_wdata;

	assign ram_we    = cmd.wr_spin || (cmd.calc_flip && flip_c);
	assign ram_wdata = cmd.wr_spin ? sv_q : ~ctr_q;

	isfu_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (site_addr(row_q, col_q)),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result word
	logic spin_c, flipped_c;

	always_comb begin
		flipped_c = !oob_c && (mode_q == MODE_FLIP) && flip_q;
		if (oob_c) begin
			spin_c = 1'b0;
		end else if (mode_q == MODE_WRITE) begin
			spin_c = sv_q;
		end else if (mode_q == MODE_FLIP) begin
			spin_c = ctr_q ^ flip_q;
		end else begin
			spin_c = ctr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_spin    <= spin_c;
			res_flipped <= flipped_c;
			res_status  <= oob_c;
		end
	end

endmodule

// ----- src/isfu_ctrl.sv -----
// Controller: sequences decode, lattice reads, evaluation and result hand-off.
`include "ising_spin_flip_update_top_assert.svh"

module isfu_ctrl import isfu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  isfu_sts_t sts,
	output isfu_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CAP  = 3'd3;
	localparam logic [2:0] S_NBJ  = 3'd4;
	localparam logic [2:0] S_EVAL = 3'd5;
	localparam logic [2:0] S_RES  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] rd_cnt_q, rd_cnt_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		rd_cnt_d = rd_cnt_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.oob) begin
					state_d = S_RES;
				end else if (sts.mode == MODE_WRITE) begin
					cmd.wr_spin = 1'b1;
					state_d = S_RES;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = NB_CTR;
					if (sts.mode == MODE_FLIP) begin
						rd_cnt_d = NB_UP;
						state_d  = S_RD;
					end else begin
						state_d = S_CAP;
					end
				end
			end
			S_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rd_cnt_q;
				rd_cnt_d   = rd_cnt_q + 3'd1;
				if (rd_cnt_q == NB_RT) begin
					state_d = S_CAP;
				end
			end
			S_CAP: begin
				state_d = (sts.mode == MODE_FLIP) ? S_NBJ : S_RES;
			end
			S_NBJ: begin
				cmd.calc_nbj = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.calc_flip = 1'b1;
				state_d = S_RES;
			end
			S_RES: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= NB_CTR;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= rd_cnt_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ISFU_ASSERT_IMPL(a_no_result_overwrite, clk, arst_n, cmd.load_out, out_free, "result overwritten while pending")
	`ISFU_ASSERT_IMPL(a_no_rd_wr_overlap, clk, arst_n, cmd.rd_en, !(cmd.wr_spin || cmd.calc_flip), "lattice read and write in one cycle")
	`ISFU_ASSERT_NEXT(a_accept_to_decode, clk, arst_n, in_valid && in_ready, state_q == S_DEC, "accepted word not decoded")
	`ISFU_ASSERT_IMPL(a_rd_cnt_range, clk, arst_n, state_q == S_RD, rd_cnt_q >= NB_UP && rd_cnt_q <= NB_RT, "neighbor read count out of range")

endmodule

// ----- src/ising_spin_flip_update_top.sv -----
// Top level of the Ising spin-flip update block.
// The block holds a toroidal lattice of +1/-1 spins (one bit per site, 128 x 128
// storage) in a single-port-write / single-port-read RAM whose read data is
// registered. Each input word is a write (mode 0), a read (mode 1, and the
// unused mode 3) or a flip attempt (mode 2) at (row, col). A flip attempt reads
// the site and its four wrapped neighbors, forms E = 2(B + nb*J)*s in Q8.8
// (plus inertia_penalty when s = -1 and all neighbors are -1), and flips the
// site when E is below the word's threshold. Coordinates at or beyond the
// rows/cols in use (clipped to storage) give status 1 and change nothing.
// One word is in flight at a time. A flip attempt is paced by the RAM's
// one read port returning one site per cycle (five reads), followed by a
// multiply stage (nb*J) and an add/compare stage that also writes the
// flipped spin back. The next word is taken while a finished result word
// still waits on rsp; the block only stalls if a second result is ready
// before the first is taken.
// The lattice has no reset; every site must be written before it is read,
// directly or as a neighbor. Configuration writes are always accepted and
// must only be issued while the block is idle.
module ising_spin_flip_update_top import isfu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	isfu_in_if.sink    req,
	isfu_out_if.source rsp,
	isfu_cfg_if.sink   cfg
);

	isfu_cmd_t cmd;
	isfu_sts_t sts;

	assign cfg.ready = 1'b1;

	isfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	isfu_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (req.mode),
		.row         (req.row),
		.col         (req.col),
		.spin_value  (req.spin_value),
		.threshold   (req.threshold),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.res_spin    (rsp.spin),
		.res_flipped (rsp.flipped),
		.res_status  (rsp.status)
	);

endmodule
